[sv/wssu_pkg.sv]
// wssu_pkg: shared constants, types and request and response structs for
// the windowed sample statistics unit; used by every module but wssu_ram
// no dependencies

package wssu_pkg;

  // window geometry
  localparam int WINDOW  = 64;
  localparam int LABELS  = 4;
  localparam int SLOT_W  = $clog2(WINDOW);
  localparam int LABEL_W = $clog2(LABELS);
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int VADDR_W = SLOT_W + LABEL_W;

  // field widths
  localparam int IDX_W   = 64;
  localparam int VAL_W   = 32;
  localparam int STD_W   = 31;
  localparam int LCNT_W  = 3;

  // arithmetic widths
  localparam int SUM_W   = VAL_W + SLOT_W + 1;
  localparam int NUM_W   = SUM_W + 2;
  localparam int SQ_W    = 2 * VAL_W;
  localparam int DVD_W   = SQ_W + SLOT_W;
  localparam int DSR_W   = CNT_W + 1;
  localparam int ROOT_W  = SQ_W / 2;

  // register reset values
  localparam logic [CNT_W-1:0]  WLEN_RST = CNT_W'(WINDOW);
  localparam logic [LCNT_W-1:0] LCNT_RST = LCNT_W'(1);
  localparam logic [VAL_W-1:0]  OMAX_RST = {1'b0, {(VAL_W-1){1'b1}}};

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_WINDOW_LEN  = 3'd0,
    REG_OUTLIER_MAX = 3'd1,
    REG_LABEL_COUNT = 3'd2,
    REG_DEFAULT0    = 3'd3,
    REG_DEFAULT1    = 3'd4,
    REG_DEFAULT2    = 3'd5,
    REG_DEFAULT3    = 3'd6
  } cfg_reg_t;

  // request kinds
  typedef enum logic {
    KIND_ADD   = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_CMP,
    S_ADD_END,
    S_ADD_FILL,
    S_Q_WALK,
    S_MEAN,
    S_VAR,
    S_VDIV,
    S_SQRT,
    S_OUT
  } state_t;

  // serial divider
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  // serial square root
  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

endpackage

[sv/wssu_ram.sv]
// wssu_ram: generic single write port, single read port ram with registered read
// no dependencies

module wssu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/wssu_div.sv]
// wssu_div: restoring divider, one quotient bit per cycle
// depends on wssu_pkg

module wssu_div
  import wssu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int STEP_W = $clog2(DVD_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [DSR_W-1:0]  rem_r, rem_nxt;
  logic [DSR_W-1:0]  dsr_r, dsr_nxt;
  logic [DSR_W:0]    rem_sh;
  logic              ge;

  // one shift-subtract step
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    rem_sh   = {rem_r, dvd_r[DVD_W-1]};
    ge       = rem_sh >= {1'b0, dsr_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(DVD_W - 1);
      dvd_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? DSR_W'(rem_sh - {1'b0, dsr_r}) : DSR_W'(rem_sh);
      dvd_nxt = {dvd_r[DVD_W-2:0], ge};
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule

[sv/wssu_sqrt.sv]
// wssu_sqrt: digit-by-digit integer square root, one root bit per cycle
// depends on wssu_pkg

module wssu_sqrt
  import wssu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  sqrt_req_t req,
  output sqrt_rsp_t rsp
);

  localparam int STEP_W = $clog2(ROOT_W);
  localparam int REM_W  = ROOT_W + 4;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SQ_W-1:0]   rad_r, rad_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;

  // bring down two radicand bits, try appending a one to the root
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    rem_sh   = {rem_r[REM_W-3:0], rad_r[SQ_W-1 -: 2]};
    trial    = REM_W'({root_r, 2'b01});
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(ROOT_W - 1);
      rad_nxt  = req.radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rad_nxt = {rad_r[SQ_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

endmodule

[sv/windowed_sample_statistics_unit.sv]
// windowed_sample_statistics_unit: top level, request sequencer around the
// index ram and value ram; uses wssu_pkg, wssu_ram, wssu_div and wssu_sqrt
//
//  channel | direction | handshake            | payload
//  in      | request   | in_valid / in_ready  | kind, label, sample_index, sample_value
//  out     | result    | out_valid/out_ready  | valid_count, min, max, mean, std
//  cfg     | write     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// an add reads the index ram and then compares for each window slot searched,
// then closes the search and, when the window advances, fills the new slot
// with one value ram write per label; a query that finds samples makes a
// value pass, a mean divide, a deviation pass, a variance divide and a square
// root, the divides and root in the serial divider and root unit; synchronous
// active-low reset empties the window at once through per-slot valid bits; a
// finished result waits in the output register while the next request is taken

module windowed_sample_statistics_unit
  import wssu_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_kind,
  input  logic [LABEL_W-1:0]      in_label,
  input  logic [IDX_W-1:0]        in_sample_index,
  input  logic signed [VAL_W-1:0] in_sample_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CNT_W-1:0]        out_valid_count,
  output logic signed [VAL_W-1:0] out_min_value,
  output logic signed [VAL_W-1:0] out_max_value,
  output logic signed [VAL_W-1:0] out_mean_value,
  output logic [STD_W-1:0]        out_std_value,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [VAL_W-1:0]        cfg_data
);

  // configuration registers
  logic [CNT_W-1:0]        wlen_r;
  logic signed [VAL_W-1:0] omax_r;
  logic [LCNT_W-1:0]       lcnt_r;
  logic signed [VAL_W-1:0] dflt_r [LABELS];
  logic                    cfg_wr;
  logic                    reshape;

  // window control state
  logic [WINDOW-1:0] valid_r, valid_nxt;
  logic [SLOT_W-1:0] oldest_r, oldest_nxt;

  // sequencer registers
  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        k_r, k_nxt;
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic [LABEL_W-1:0]      lbl_r, lbl_nxt;
  logic [IDX_W-1:0]        sidx_r, sidx_nxt;
  logic signed [VAL_W-1:0] sval_r, sval_nxt;
  logic [IDX_W-1:0]        newest_idx_r, newest_idx_nxt;
  logic [LABEL_W-1:0]      fill_r, fill_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [VAL_W-1:0] mn_r, mn_nxt;
  logic signed [VAL_W-1:0] mx_r, mx_nxt;
  logic signed [VAL_W-1:0] mean_r, mean_nxt;
  logic                    neg_r, neg_nxt;
  logic                    pend_r, pend_nxt;
  logic                    pend2_r, pend2_nxt;
  logic                    pend3_r, pend3_nxt;
  logic [VAL_W-1:0]        ad_r, ad_nxt;
  logic [SQ_W-1:0]         t_r, t_nxt;
  logic [DVD_W-1:0]        tsum_r, tsum_nxt;
  logic [STD_W-1:0]        std_r, std_nxt;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]        out_cnt_r, out_cnt_nxt;
  logic signed [VAL_W-1:0] out_min_r, out_min_nxt;
  logic signed [VAL_W-1:0] out_max_r, out_max_nxt;
  logic signed [VAL_W-1:0] out_mean_r, out_mean_nxt;
  logic [STD_W-1:0]        out_std_r, out_std_nxt;

  // memory ports
  logic                    idx_we;
  logic [SLOT_W-1:0]       idx_waddr;
  logic [IDX_W-1:0]        idx_wdata;
  logic [IDX_W-1:0]        idx_rdata;
  logic                    val_we;
  logic [VADDR_W-1:0]      val_waddr;
  logic [VAL_W-1:0]        val_wdata;
  logic [VADDR_W-1:0]      val_raddr;
  logic [VAL_W-1:0]        val_rdata;

  // arithmetic units
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;

  // helpers
  logic [CNT_W-1:0]        n_eff;
  logic [LCNT_W-1:0]       n_lab;
  logic [SLOT_W-1:0]       newest_slot;
  logic [SLOT_W-1:0]       prev_slot;
  logic                    lbl_ok;
  logic signed [VAL_W-1:0] clamped;
  logic signed [VAL_W-1:0] x_val;
  logic signed [NUM_W-1:0] num;
  logic [DSR_W-1:0]        den;
  logic [NUM_W-1:0]        num_mag;
  logic signed [VAL_W:0]   diff;
  logic [VAL_W-1:0]        q_low;
  logic                    issue;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign reshape   = cfg_wr && (cfg_index == REG_WINDOW_LEN || cfg_index == REG_LABEL_COUNT);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= WLEN_RST;
      omax_r <= OMAX_RST;
      lcnt_r <= LCNT_RST;
      for (int i = 0; i < LABELS; i++) begin
        dflt_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_WINDOW_LEN:  wlen_r    <= cfg_data[CNT_W-1:0];
        REG_OUTLIER_MAX: omax_r    <= cfg_data;
        REG_LABEL_COUNT: lcnt_r    <= cfg_data[LCNT_W-1:0];
        REG_DEFAULT0:    dflt_r[0] <= cfg_data;
        REG_DEFAULT1:    dflt_r[1] <= cfg_data;
        REG_DEFAULT2:    dflt_r[2] <= cfg_data;
        REG_DEFAULT3:    dflt_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective window length and label count
  always_comb begin
    if (wlen_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (wlen_r > CNT_W'(WINDOW)) begin
      n_eff = CNT_W'(WINDOW);
    end else begin
      n_eff = wlen_r;
    end
    if (lcnt_r == '0) begin
      n_lab = LCNT_W'(1);
    end else if (lcnt_r > LCNT_W'(LABELS)) begin
      n_lab = LCNT_W'(LABELS);
    end else begin
      n_lab = lcnt_r;
    end
  end

  // slot arithmetic in the circular window
  assign newest_slot = (oldest_r == '0) ? SLOT_W'(n_eff - 1'b1) : oldest_r - 1'b1;
  assign prev_slot   = (slot_r == '0) ? SLOT_W'(n_eff - 1'b1) : slot_r - 1'b1;
  assign lbl_ok      = LCNT_W'(in_label) < n_lab;
  assign clamped     = (in_sample_value > omax_r) ? omax_r : in_sample_value;
  assign x_val       = val_rdata;

  // mean numerator and denominator
  assign num     = (NUM_W'(sum_r) <<< 1) + $signed(NUM_W'(cnt_r));
  assign den     = {cnt_r, 1'b0};
  assign num_mag = num[NUM_W-1] ? NUM_W'(-num + $signed(NUM_W'(den)) - 1)
                                : NUM_W'(num);
  assign diff    = $signed({x_val[VAL_W-1], x_val}) - $signed({mean_r[VAL_W-1], mean_r});
  assign q_low   = div_rsp.quotient[VAL_W-1:0];

  // memory addresses
  assign val_raddr = {slot_r, lbl_r};

  // sequencer next state and datapath
  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    oldest_nxt     = oldest_r;
    k_nxt          = k_r;
    slot_nxt       = slot_r;
    lbl_nxt        = lbl_r;
    sidx_nxt       = sidx_r;
    sval_nxt       = sval_r;
    newest_idx_nxt = newest_idx_r;
    fill_nxt       = fill_r;
    cnt_nxt        = cnt_r;
    sum_nxt        = sum_r;
    mn_nxt         = mn_r;
    mx_nxt         = mx_r;
    mean_nxt       = mean_r;
    neg_nxt        = neg_r;
    pend_nxt       = 1'b0;
    pend2_nxt      = 1'b0;
    pend3_nxt      = 1'b0;
    ad_nxt         = ad_r;
    t_nxt          = t_r;
    tsum_nxt       = tsum_r;
    std_nxt        = std_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_cnt_nxt    = out_cnt_r;
    out_min_nxt    = out_min_r;
    out_max_nxt    = out_max_r;
    out_mean_nxt   = out_mean_r;
    out_std_nxt    = out_std_r;
    idx_we         = 1'b0;
    idx_waddr      = oldest_r;
    idx_wdata      = sidx_r;
    val_we         = 1'b0;
    val_waddr      = {slot_r, lbl_r};
    val_wdata      = sval_r;
    div_req        = '0;
    sqrt_req       = '0;
    issue          = 1'b0;
    in_ready       = (state_r == S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          lbl_nxt  = in_label;
          slot_nxt = newest_slot;
          k_nxt    = '0;
          if (in_kind == KIND_ADD) begin
            sidx_nxt       = in_sample_index;
            sval_nxt       = clamped;
            newest_idx_nxt = '0;
            if (lbl_ok && in_sample_index != '0) begin
              state_nxt = S_ADD_RD;
            end
          end else begin
            mn_nxt   = dflt_r[in_label];
            mx_nxt   = dflt_r[in_label];
            cnt_nxt  = '0;
            sum_nxt  = '0;
            mean_nxt = '0;
            std_nxt  = '0;
            state_nxt = lbl_ok ? S_Q_WALK : S_OUT;
          end
        end
      end

      // search from the newest slot for a matching index
      S_ADD_RD: begin
        state_nxt = valid_r[slot_r] ? S_ADD_CMP : S_ADD_END;
      end

      S_ADD_CMP: begin
        if (k_r == '0) begin
          newest_idx_nxt = idx_rdata;
        end
        if (idx_rdata == sidx_r) begin
          val_we    = 1'b1;
          state_nxt = S_IDLE;
        end else if (idx_rdata < sidx_r || k_r + 1'b1 == n_eff) begin
          state_nxt = S_ADD_END;
        end else begin
          k_nxt     = k_r + 1'b1;
          slot_nxt  = prev_slot;
          state_nxt = S_ADD_RD;
        end
      end

      // advance the window when the index is newer than all stored ones
      S_ADD_END: begin
        if (sidx_r > newest_idx_r) begin
          idx_we              = 1'b1;
          valid_nxt[oldest_r] = 1'b1;
          fill_nxt            = '0;
          state_nxt           = S_ADD_FILL;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_ADD_FILL: begin
        val_we    = 1'b1;
        val_waddr = {oldest_r, fill_r};
        val_wdata = (fill_r == lbl_r) ? sval_r : dflt_r[fill_r];
        if (fill_r == LABEL_W'(LABELS - 1)) begin
          oldest_nxt = (CNT_W'(oldest_r) + 1'b1 == n_eff) ? '0 : oldest_r + 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          fill_nxt = fill_r + 1'b1;
        end
      end

      // first pass: count, extremes and sum, one read per cycle
      S_Q_WALK: begin
        issue = (k_r < n_eff) && valid_r[slot_r];
        if (pend_r) begin
          if (cnt_r == '0 || x_val < mn_r) begin
            mn_nxt = x_val;
          end
          if (cnt_r == '0 || x_val > mx_r) begin
            mx_nxt = x_val;
          end
          sum_nxt = sum_r + SUM_W'(x_val);
          cnt_nxt = cnt_r + 1'b1;
        end
        if (issue) begin
          pend_nxt = 1'b1;
          k_nxt    = k_r + 1'b1;
          slot_nxt = prev_slot;
        end else if (!pend_r) begin
          if (cnt_r == '0) begin
            state_nxt = S_OUT;
          end else begin
            neg_nxt          = num[NUM_W-1];
            div_req.start    = 1'b1;
            div_req.dividend = DVD_W'(num_mag);
            div_req.divisor  = den;
            state_nxt        = S_MEAN;
          end
        end
      end

      // rounded mean from the divider
      S_MEAN: begin
        if (div_rsp.done) begin
          mean_nxt  = neg_r ? -q_low : q_low;
          k_nxt     = '0;
          slot_nxt  = newest_slot;
          tsum_nxt  = '0;
          state_nxt = S_VAR;
        end
      end

      // second pass: squared deviations through a three-stage pipe
      S_VAR: begin
        issue = k_r < cnt_r;
        if (pend_r) begin
          ad_nxt = diff[VAL_W] ? VAL_W'(-diff) : VAL_W'(diff);
        end
        if (pend2_r) begin
          t_nxt = SQ_W'(ad_r) * SQ_W'(ad_r);
        end
        if (pend3_r) begin
          tsum_nxt = tsum_r + DVD_W'(t_r);
        end
        pend2_nxt = pend_r;
        pend3_nxt = pend2_r;
        if (issue) begin
          pend_nxt = 1'b1;
          k_nxt    = k_r + 1'b1;
          slot_nxt = prev_slot;
        end else if (!pend_r && !pend2_r && !pend3_r) begin
          div_req.start    = 1'b1;
          div_req.dividend = tsum_r;
          div_req.divisor  = DSR_W'(cnt_r);
          state_nxt        = S_VDIV;
        end
      end

      S_VDIV: begin
        if (div_rsp.done) begin
          sqrt_req.start    = 1'b1;
          sqrt_req.radicand = div_rsp.quotient[SQ_W-1:0];
          state_nxt         = S_SQRT;
        end
      end

      // saturate the root to the output width
      S_SQRT: begin
        if (sqrt_rsp.done) begin
          std_nxt   = (sqrt_rsp.root[ROOT_W-1:STD_W] != '0) ? '1
                                                           : sqrt_rsp.root[STD_W-1:0];
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = cnt_r;
          out_min_nxt   = mn_r;
          out_max_nxt   = mx_r;
          out_mean_nxt  = mean_r;
          out_std_nxt   = std_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // reshaping the window empties it
    if (reshape) begin
      valid_nxt  = '0;
      oldest_nxt = '0;
    end
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      oldest_r    <= '0;
      pend_r      <= 1'b0;
      pend2_r     <= 1'b0;
      pend3_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      oldest_r    <= oldest_nxt;
      pend_r      <= pend_nxt;
      pend2_r     <= pend2_nxt;
      pend3_r     <= pend3_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    slot_r       <= slot_nxt;
    lbl_r        <= lbl_nxt;
    sidx_r       <= sidx_nxt;
    sval_r       <= sval_nxt;
    newest_idx_r <= newest_idx_nxt;
    fill_r       <= fill_nxt;
    cnt_r        <= cnt_nxt;
    sum_r        <= sum_nxt;
    mn_r         <= mn_nxt;
    mx_r         <= mx_nxt;
    mean_r       <= mean_nxt;
    neg_r        <= neg_nxt;
    ad_r         <= ad_nxt;
    t_r          <= t_nxt;
    tsum_r       <= tsum_nxt;
    std_r        <= std_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_min_r    <= out_min_nxt;
    out_max_r    <= out_max_nxt;
    out_mean_r   <= out_mean_nxt;
    out_std_r    <= out_std_nxt;
  end

  // index store, one entry per slot
  wssu_ram #(
    .WIDTH(IDX_W),
    .DEPTH(WINDOW)
  ) u_idx_ram (
    .clk   (clk),
    .we    (idx_we),
    .waddr (idx_waddr),
    .wdata (idx_wdata),
    .raddr (slot_r),
    .rdata (idx_rdata)
  );

  // value store, one entry per slot and label
  wssu_ram #(
    .WIDTH(VAL_W),
    .DEPTH(WINDOW * LABELS)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  wssu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  wssu_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sqrt_req),
    .rsp   (sqrt_rsp)
  );

  assign out_valid       = out_valid_r;
  assign out_valid_count = out_cnt_r;
  assign out_min_value   = out_min_r;
  assign out_max_value   = out_max_r;
  assign out_mean_value  = out_mean_r;
  assign out_std_value   = out_std_r;

endmodule

[sv/wssu_checker.sv]
// wssu_checker: port-level checks on the windowed sample statistics unit
// depends on wssu_pkg; bound to windowed_sample_statistics_unit below

module wssu_checker
  import wssu_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    in_kind,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [CNT_W-1:0]        out_valid_count,
  input logic signed [VAL_W-1:0] out_min_value,
  input logic signed [VAL_W-1:0] out_max_value,
  input logic signed [VAL_W-1:0] out_mean_value,
  input logic [STD_W-1:0]        out_std_value
);

  // a stalled result holds its mean, deviation and count
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mean_value)
      && $stable(out_std_value) && $stable(out_valid_count))
    else $error("stalled result changed");

  // no result rises right after an add request is taken
  a_add_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == KIND_ADD |=> !$rose(out_valid))
    else $error("add request produced a result");

  // count never exceeds the window
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_valid_count <= CNT_W'(WINDOW))
    else $error("count beyond window");

  // empty window reports zero mean and deviation
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_count == '0 |-> out_mean_value == '0 && out_std_value == '0)
    else $error("empty window with nonzero mean or std");

  // extremes are ordered and bracket the mean
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_count != '0 |-> out_min_value <= out_max_value
      && out_mean_value >= out_min_value && out_mean_value <= out_max_value)
    else $error("min, mean, max out of order");

endmodule

bind windowed_sample_statistics_unit wssu_checker u_wssu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_kind         (in_kind),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_valid_count (out_valid_count),
  .out_min_value   (out_min_value),
  .out_max_value   (out_max_value),
  .out_mean_value  (out_mean_value),
  .out_std_value   (out_std_value)
);
